// File: sv/text_console_writer_macros.svh
// assertion macros used by the checker file
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/tcw_pkg.sv
package tcw_pkg;

	// screen geometry
	localparam int COLS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = ROWS * COLS;
	localparam int COL_W = $clog2(COLS);
	localparam int ROW_W = (ROWS > 2) ? $clog2(ROWS) : 1;
	localparam int ADDR_W = $clog2(CELLS);

	// field widths
	localparam int OP_W = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W = 11;
	localparam int POS_W = 11;
	localparam int CELL_W = 16;
	localparam int COLOR_W = 8;
	localparam int EXT_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

	// stream packing
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 32;

	// character codes
	localparam logic [CHAR_W-1:0] CH_BS = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
	localparam int TAB_STEP = 4;

	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

	// item kinds
	typedef enum logic [OP_W-1:0] {
		OP_PUT = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// datapath commands
	typedef enum logic [2:0] {
		DP_NOP,
		DP_LOAD,
		DP_EXEC,
		DP_INIT,
		DP_FILL,
		DP_COPY,
		DP_BLANK,
		DP_OUT
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t cmd;
	} cmd_t;

	typedef struct packed {
		op_t op;
		logic scroll;
		logic fill_last;
		logic copy_last;
	} sts_t;

endpackage

// File: sv/tcw_ctrl.sv
module tcw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  tcw_pkg::sts_t sts,
	output tcw_pkg::cmd_t cmd
);
	import tcw_pkg::*;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_FILL,
		ST_COPY,
		ST_BLANK,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	// command decode from state
	always_comb begin
		cmd.cmd = DP_NOP;
		unique case (state_q)
			ST_INIT:   cmd.cmd = DP_INIT;
			ST_IDLE:   cmd.cmd = s_tvalid ? DP_LOAD : DP_NOP;
			ST_EXEC:   cmd.cmd = DP_EXEC;
			ST_FILL:   cmd.cmd = DP_FILL;
			ST_COPY:   cmd.cmd = DP_COPY;
			ST_BLANK:  cmd.cmd = DP_BLANK;
			ST_RESULT: cmd.cmd = out_free ? DP_OUT : DP_NOP;
			default:   cmd.cmd = DP_NOP;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			// result register: load a new beat or drop the one taken
			if (state_q == ST_RESULT && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					if (sts.fill_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (sts.op == OP_CLEAR)
						state_q <= ST_FILL;
					else if (sts.op == OP_PUT && sts.scroll)
						state_q <= ST_COPY;
					else
						state_q <= ST_RESULT;
				end
				ST_FILL: begin
					if (sts.fill_last)
						state_q <= ST_RESULT;
				end
				ST_COPY: begin
					if (sts.copy_last)
						state_q <= ST_BLANK;
				end
				ST_BLANK: begin
					if (sts.fill_last)
						state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_INIT;
			endcase
		end
	end

endmodule

// File: sv/tcw_datapath.sv
module tcw_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tcw_pkg::cmd_t                  cmd,
	output tcw_pkg::sts_t                  sts,
	input  logic                           cfg_we,
	input  logic [tcw_pkg::COLOR_W-1:0]    cfg_wdata,
	input  logic [tcw_pkg::OP_W-1:0]       op,
	input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
	input  logic [tcw_pkg::IDX_W-1:0]      read_index,
	output logic [tcw_pkg::OUT_DATA_W-1:0] out_data
);
	import tcw_pkg::*;

	// screen store
	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rdata_q;
	logic mem_we;
	logic mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CELL_W-1:0] mem_wdata;

	// item and state registers
	op_t op_q;
	logic [CHAR_W-1:0] char_q;
	logic [IDX_W-1:0] ridx_q;
	logic [COLOR_W-1:0] text_color_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [COL_W:0] ncol;
	logic [ROW_W:0] nrow;
	logic [ROW_W-1:0] nrow_fit;
	logic put_we;
	logic [ADDR_W-1:0] put_addr;
	logic [CELL_W-1:0] put_data;
	logic scroll;
	logic [ADDR_W-1:0] base;
	logic [ADDR_W-1:0] pos;
	logic [EXT_W-1:0] ridx_ext;
	logic ridx_ok;
	logic fill_last;
	logic copy_last;
	logic [CELL_W-1:0] blank_cell;
	logic [CELL_W-1:0] cell_out;

	assign blank_cell = {text_color_q, CH_BLANK};
	assign base = ADDR_W'(row_q) * ADDR_W'(COLS);
	assign pos = base + ADDR_W'(col_q);
	assign ridx_ext = EXT_W'(ridx_q);
	assign ridx_ok = (ridx_ext < EXT_W'(CELLS));
	assign fill_last = (cnt_q == ADDR_W'(CELLS - 1));
	assign copy_last = (cnt_q == ADDR_W'(CELLS - COLS));

	assign sts.op = op_q;
	assign sts.scroll = scroll;
	assign sts.fill_last = fill_last;
	assign sts.copy_last = copy_last;
	assign out_data = out_data_q;

	// character handling and cursor advance
	always_comb begin
		ncol = {1'b0, col_q};
		nrow = {1'b0, row_q};
		put_we = 1'b0;
		put_addr = pos;
		put_data = {text_color_q, char_q};
		case (char_q)
			CH_LF: begin
				ncol = '0;
				nrow = nrow + 1'b1;
			end
			CH_CR: ncol = '0;
			CH_TAB: ncol = ({1'b0, col_q} + (COL_W+1)'(TAB_STEP))
				& ~(COL_W+1)'(TAB_STEP - 1);
			CH_BS: begin
				if (col_q != '0) begin
					ncol = {1'b0, col_q} - 1'b1;
					put_we = 1'b1;
					put_addr = pos - 1'b1;
					put_data = blank_cell;
				end
			end
			default: begin
				put_we = 1'b1;
				ncol = {1'b0, col_q} + 1'b1;
			end
		endcase
		// wrap at the right edge
		if (ncol >= (COL_W+1)'(COLS)) begin
			ncol = '0;
			nrow = nrow + 1'b1;
		end
		// scroll past the bottom row
		scroll = (nrow >= (ROW_W+1)'(ROWS));
		nrow_fit = scroll ? ROW_W'(ROWS - 1) : nrow[ROW_W-1:0];
	end

	// store port control
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_waddr = cnt_q;
		mem_raddr = ADDR_W'(ridx_ext);
		mem_wdata = blank_cell;
		case (cmd.cmd)
			DP_EXEC: begin
				mem_we = (op_q == OP_PUT) && put_we;
				mem_waddr = put_addr;
				mem_wdata = put_data;
				mem_re = (op_q == OP_READ) && ridx_ok;
			end
			DP_INIT: begin
				mem_we = 1'b1;
				mem_wdata = {RESET_COLOR, CH_BLANK};
			end
			DP_FILL, DP_BLANK: mem_we = 1'b1;
			DP_COPY: begin
				mem_re = !copy_last;
				mem_raddr = cnt_q + ADDR_W'(COLS);
				mem_we = (cnt_q != '0);
				mem_waddr = cnt_q - 1'b1;
				mem_wdata = rdata_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	// store write and registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (mem_re)
			rdata_q <= mem[mem_raddr];
	end

	// cursor, sweep counter and color
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			cnt_q <= '0;
			text_color_q <= RESET_COLOR;
		end else begin
			if (cfg_we)
				text_color_q <= cfg_wdata;
			case (cmd.cmd)
				DP_EXEC: begin
					cnt_q <= '0;
					if (op_q == OP_PUT) begin
						row_q <= nrow_fit;
						col_q <= ncol[COL_W-1:0];
					end else if (op_q == OP_CLEAR) begin
						row_q <= '0;
						col_q <= '0;
					end
				end
				DP_INIT, DP_FILL, DP_BLANK: cnt_q <= fill_last ? '0 : cnt_q + 1'b1;
				DP_COPY: begin
					if (!copy_last)
						cnt_q <= cnt_q + 1'b1;
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// item capture and result register
	assign cell_out = (op_q == OP_READ && ridx_ok) ? rdata_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.cmd == DP_LOAD) begin
			op_q <= op_t'(op);
			char_q <= char_code;
			ridx_q <= read_index;
		end
		if (cmd.cmd == DP_OUT)
			out_data_q <= OUT_DATA_W'({cell_out, POS_W'(pos)});
	end

endmodule

// File: sv/text_console_writer.sv
// put, read and unused items: accept, execute and result load in turn; the next
// item is taken only once the result has been loaded
// scroll: a pipelined row copy through the store's read and write ports, then the last row is blanked
// clear: one cell written per cycle
// after reset the store is swept to blank cells with s_tready low;
// cfg writes are taken during that sweep
module text_console_writer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tcw_pkg::IN_DATA_W-1:0]  s_tdata,   // char_code[7:0], read_index[18:8]
	input  logic [tcw_pkg::OP_W-1:0]       s_tuser,   // op[1:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tcw_pkg::OUT_DATA_W-1:0] m_tdata,   // cursor_pos[10:0], cell_value[26:11]
	input  logic                           cfg_we,
	input  logic [tcw_pkg::COLOR_W-1:0]    cfg_wdata
);
	import tcw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// controller
	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath with screen store
	tcw_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.op         (s_tuser),
		.char_code  (s_tdata[CHAR_W-1:0]),
		.read_index (s_tdata[CHAR_W+IDX_W-1:CHAR_W]),
		.out_data   (m_tdata)
	);

endmodule

// File: sv/tcw_checker.sv
`include "text_console_writer_macros.svh"

module tcw_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [tcw_pkg::OUT_DATA_W-1:0] m_tdata
);
	import tcw_pkg::*;

	// a stalled result holds
	`TCW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// one item in work at a time
	`TCW_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while an item is in work")

	// cursor stays on the screen
	`TCW_ASSERT_NOW(a_pos_range, m_tvalid, m_tdata[POS_W-1:0] < POS_W'(CELLS), "cursor off screen")

	// padding bits of a result stay zero
	`TCW_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[OUT_DATA_W-1:POS_W+CELL_W] == '0, "result padding set")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
